FILE: rtl/sws_pkg.sv
// Shared widths, codes and types of the sliding-window sender.
package sws_pkg;

    // Field widths fixed by the stream formats.
    localparam int ActionW  = 2;
    localparam int PayloadW = 32;
    localparam int AckW     = 6;
    localparam int KindW    = 3;
    localparam int SeqOutW  = 6;
    localparam int WinW     = 6;

    // Packed widths of the stream buses, rounded up to whole bytes.
    localparam int InDataW  = 40;
    localparam int OutDataW = 48;

    // Defaults for the top-level parameters.
    localparam int DefSeqSpace   = 8;
    localparam int DefPayloadBits = 32;

    // Register reset value and the duplicate acknowledgement threshold.
    localparam logic [WinW-1:0] WinReset    = 6'd4;
    localparam logic [1:0]      DupAckLimit = 2'd3;

    // Request kinds carried on the input tuser.
    localparam logic [ActionW-1:0] ActSend    = 2'd0;
    localparam logic [ActionW-1:0] ActAck     = 2'd1;
    localparam logic [ActionW-1:0] ActTimeout = 2'd2;

    // Result kinds carried on the output tuser.
    localparam logic [KindW-1:0] KindRefused   = 3'd0;
    localparam logic [KindW-1:0] KindNew       = 3'd1;
    localparam logic [KindW-1:0] KindRetx      = 3'd2;
    localparam logic [KindW-1:0] KindAckTaken  = 3'd3;
    localparam logic [KindW-1:0] KindAckIgnore = 3'd4;
    localparam logic [KindW-1:0] KindAckBad    = 3'd5;
    localparam logic [KindW-1:0] KindEmpty     = 3'd6;

    // Control of the payload store port.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

FILE: rtl/sws_store.sv
// Payload store: one write port and one registered read port.
module sws_store #(
    parameter int DEPTH  = sws_pkg::DefSeqSpace,
    parameter int ADDR_W = 3,
    parameter int DATA_W = sws_pkg::DefPayloadBits
) (
    input  logic                i_clk,
    input  sws_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [DATA_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [DATA_W-1:0]   o_rdata
);
    import sws_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Read data is held until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sliding_window_sender_unit.sv
// Top level of the sliding-window sender: request decoding, window state and result output.
//
//  Channel   Direction  Signals                                  Contents
//  s_axis    in         tvalid/tready/tdata[39:0]/tuser[1:0]     send, ACK or timeout request
//  m_axis    out        tvalid/tready/tdata[47:0]/tuser[2:0]     result items, tlast ends a run
//  cfg       in         i_cfg_wr_en/i_cfg_wr_data[5:0]           window size register
//
// A request is decoded in the cycle it is accepted and its result is loaded into the output
// register in the emit state, once the output register is free. A timeout reads the payload
// store first, and a fast retransmit of n packets makes one store read and one output load
// for each packet. An unused request kind gives no result. A stalled output holds the
// sequencer in its output state. Synchronous active-low reset clears the window state and
// sets the window size to four; the store is always written before it is read.
module sliding_window_sender_unit #(
    parameter int SEQ_SPACE    = sws_pkg::DefSeqSpace,
    parameter int PAYLOAD_BITS = sws_pkg::DefPayloadBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: payload_word[31:0], ack_number[37:32], ack_checksum_ok[38], zero[39]
    input  logic [sws_pkg::InDataW-1:0]     s_axis_tdata,
    // tuser: action[1:0]
    input  logic [sws_pkg::ActionW-1:0]     s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: packet_seq[5:0], packet_payload[37:6], timer_restart[38], timer_stop[39],
    //        timer_seq[45:40], window_full[46], zero[47]
    output logic [sws_pkg::OutDataW-1:0]    m_axis_tdata,
    // tuser: result_kind[2:0]
    output logic [sws_pkg::KindW-1:0]       m_axis_tuser,
    output logic                            m_axis_tlast,
    // Window size register.
    input  logic                            i_cfg_wr_en,
    input  logic [sws_pkg::WinW-1:0]        i_cfg_wr_data
);
    import sws_pkg::*;

    // Sequence numbers need just enough bits for the sequence space.
    localparam int SEQ_W   = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    // Only the low payload bits that survive both the payload mask and the field width are kept.
    localparam int STORE_W = (PAYLOAD_BITS < PayloadW) ? PAYLOAD_BITS : PayloadW;
    localparam logic [WinW-1:0]  MaxWin  = WinW'(SEQ_SPACE - 1);
    localparam logic [SEQ_W-1:0] SeqLast = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SEQ_W:0]   SeqSpan = (SEQ_W+1)'(SEQ_SPACE);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Modular distance a - b, both already below the sequence space.
    function automatic logic [SEQ_W-1:0] f_dist(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[SEQ_W]) begin
            d = d + SeqSpan;
        end
        return d[SEQ_W-1:0];
    endfunction

    // Modular increment.
    function automatic logic [SEQ_W-1:0] f_inc(input logic [SEQ_W-1:0] a);
        return (a == SeqLast) ? '0 : a + SEQ_W'(1);
    endfunction

    // Request fields.
    logic [ActionW-1:0]  w_action;
    logic [PayloadW-1:0] w_payload;
    logic [AckW-1:0]     w_ack_raw;
    logic                w_ack_ok;
    assign w_action  = s_axis_tuser;
    assign w_payload = s_axis_tdata[PayloadW-1:0];
    assign w_ack_raw = s_axis_tdata[PayloadW +: AckW];
    assign w_ack_ok  = s_axis_tdata[PayloadW + AckW];

    // The ACK number reduced to the sequence space through a constant table.
    logic [SEQ_W-1:0] w_ack_mod_tab [2**AckW];
    for (genvar g = 0; g < 2**AckW; g++) begin : g_ack_mod
        assign w_ack_mod_tab[g] = SEQ_W'(g % SEQ_SPACE);
    end

    // Control registers.
    logic [1:0]        r_state,       n_state;
    logic [WinW-1:0]   r_window_size, n_window_size;
    logic [SEQ_W-1:0]  r_base,        n_base;
    logic [SEQ_W-1:0]  r_next,        n_next;
    logic [1:0]        r_dup,         n_dup;
    logic [SEQ_W-1:0]  r_left,        n_left;
    logic              r_out_valid,   n_out_valid;

    // Payload registers of the request in flight and of the output.
    logic [KindW-1:0]    r_kind,     n_kind;
    logic [SEQ_W-1:0]    r_seq,      n_seq;
    logic [STORE_W-1:0]  r_pay,      n_pay;
    logic                r_restart,  n_restart;
    logic                r_stop,     n_stop;
    logic                r_use_mem,  n_use_mem;
    logic [OutDataW-1:0] r_out_data, n_out_data;
    logic [KindW-1:0]    r_out_user, n_out_user;
    logic                r_out_last, n_out_last;

    // Store port.
    t_mem_ctl           w_mem_ctl;
    logic [STORE_W-1:0] w_mem_rdata;

    // Derived window figures.
    logic [WinW-1:0]  w_eff_win;
    logic [SEQ_W-1:0] w_out_cnt;
    logic [SEQ_W-1:0] w_ack;
    logic [SEQ_W-1:0] w_ack_dist;
    logic [1:0]       w_dup_inc;
    logic             w_full;
    logic             w_accept;
    logic             w_out_free;
    logic [STORE_W-1:0] w_emit_pay;

    assign w_eff_win  = (r_window_size > MaxWin) ? MaxWin : r_window_size;
    assign w_out_cnt  = f_dist(r_next, r_base);
    assign w_full     = (WinW'(w_out_cnt) >= w_eff_win);
    assign w_ack      = w_ack_mod_tab[w_ack_raw];
    assign w_ack_dist = f_dist(w_ack, r_base);
    assign w_dup_inc  = r_dup + 2'd1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit_pay    = r_use_mem ? w_mem_rdata : r_pay;

    always_comb begin
        n_state       = r_state;
        n_window_size = i_cfg_wr_en ? i_cfg_wr_data : r_window_size;
        n_base        = r_base;
        n_next        = r_next;
        n_dup         = r_dup;
        n_left        = r_left;
        n_out_valid   = r_out_valid;
        n_kind        = r_kind;
        n_seq         = r_seq;
        n_pay         = r_pay;
        n_restart     = r_restart;
        n_stop        = r_stop;
        n_use_mem     = r_use_mem;
        n_out_data    = r_out_data;
        n_out_user    = r_out_user;
        n_out_last    = r_out_last;
        w_mem_ctl     = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // Defaults for a single result that carries no packet.
                    n_seq     = '0;
                    n_pay     = '0;
                    n_restart = 1'b0;
                    n_stop    = 1'b0;
                    n_use_mem = 1'b0;
                    n_left    = '0;
                    n_state   = ST_EMIT;
                    case (w_action)
                        ActSend: begin
                            if (w_full) begin
                                n_kind = KindRefused;
                            end else begin
                                // The new payload goes to the store and straight out.
                                w_mem_ctl.wr_en = 1'b1;
                                n_kind    = KindNew;
                                n_seq     = r_next;
                                n_pay     = STORE_W'(w_payload);
                                n_restart = (r_next == r_base);
                                n_next    = f_inc(r_next);
                            end
                        end
                        ActAck: begin
                            if (w_out_cnt == '0) begin
                                n_kind = KindEmpty;
                            end else if (!w_ack_ok) begin
                                n_kind = KindAckBad;
                            end else if (w_ack_dist < w_out_cnt) begin
                                // Cumulative acknowledgement: the base moves past it.
                                n_kind    = KindAckTaken;
                                n_dup     = '0;
                                n_base    = f_inc(w_ack);
                                n_restart = (w_ack_dist != w_out_cnt - SEQ_W'(1));
                                n_stop    = (w_ack_dist == w_out_cnt - SEQ_W'(1));
                            end else if (w_ack == f_dist(r_base, SEQ_W'(1))) begin
                                if (w_dup_inc == DupAckLimit) begin
                                    // Fast retransmit of every outstanding packet.
                                    n_dup     = '0;
                                    n_kind    = KindRetx;
                                    n_seq     = r_base;
                                    n_restart = 1'b1;
                                    n_use_mem = 1'b1;
                                    n_left    = w_out_cnt - SEQ_W'(1);
                                    n_state   = ST_READ;
                                end else begin
                                    n_dup  = w_dup_inc;
                                    n_kind = KindAckIgnore;
                                end
                            end else begin
                                n_kind = KindAckIgnore;
                            end
                        end
                        ActTimeout: begin
                            n_dup = '0;
                            if (w_out_cnt == '0) begin
                                n_kind = KindEmpty;
                                n_stop = 1'b1;
                            end else begin
                                n_kind    = KindRetx;
                                n_seq     = r_base;
                                n_restart = 1'b1;
                                n_use_mem = 1'b1;
                                n_state   = ST_READ;
                            end
                        end
                        default: begin
                            // Unused request kind: nothing to report.
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                w_mem_ctl.rd_en = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    // Window state is already final here, so timer_seq and window_full
                    // reflect the position after the request.
                    n_out_valid = 1'b1;
                    n_out_user  = r_kind;
                    n_out_last  = (r_left == '0);
                    n_out_data  = {1'b0, w_full, SeqOutW'(r_base), r_stop, r_restart,
                                   PayloadW'(w_emit_pay), SeqOutW'(r_seq)};
                    if (r_left != '0) begin
                        n_left    = r_left - SEQ_W'(1);
                        n_seq     = f_inc(r_seq);
                        n_restart = 1'b0;
                        n_state   = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_size <= WinReset;
            r_base        <= '0;
            r_next        <= '0;
            r_dup         <= '0;
            r_left        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_base        <= n_base;
            r_next        <= n_next;
            r_dup         <= n_dup;
            r_left        <= n_left;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_seq      <= n_seq;
        r_pay      <= n_pay;
        r_restart  <= n_restart;
        r_stop     <= n_stop;
        r_use_mem  <= n_use_mem;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    // Writes happen only when a request is accepted and reads only in the read state, so the
    // two ports never touch the same entry in one cycle.
    sws_store #(
        .DEPTH  (SEQ_SPACE),
        .ADDR_W (SEQ_W),
        .DATA_W (STORE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (r_next),
        .i_wdata (STORE_W'(w_payload)),
        .i_raddr (r_seq),
        .o_rdata (w_mem_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule
